// ----- rtl/core/tpm_pkg.sv -----
`timescale 1ns / 1ps

package tpm_pkg;

    // default number of stamps held on each side
    localparam int unsigned DEPTH_DEFAULT = 16;

    // field widths
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned DIFF_W  = 20;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned ACT_W   = 2;

    // stream payload widths
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned S_USER_W = ACT_W;
    localparam int unsigned M_DATA_W = 64;
    localparam int unsigned M_USER_W = 2;
    localparam int unsigned M_PAD_W  = M_DATA_W - (2 * POS_W + DIFF_W + STAMP_W);

    // max_difference after reset
    localparam logic [DIFF_W-1:0] MAX_DIFF_RESET = DIFF_W'(500);

    // input beat kinds
    typedef enum logic [ACT_W-1:0] {
        ACT_LIDAR  = 2'd0,
        ACT_CAMERA = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LROW,
        ST_SCAN,
        ST_RESULT
    } t_state;

    // verdict of the compare unit for one pair
    typedef struct packed {
        logic              hit;
        logic              zero;
        logic [DIFF_W-1:0] diff;
    } t_cmp_res;

endpackage

// ----- rtl/core/tpm_pair_unit.sv -----
`timescale 1ns / 1ps

module tpm_pair_unit (
    input  logic [tpm_pkg::STAMP_W-1:0] i_lidar_stamp,
    input  logic [tpm_pkg::STAMP_W-1:0] i_camera_stamp,
    input  logic                        i_found,
    input  logic [tpm_pkg::DIFF_W-1:0]  i_best_diff,
    input  logic [tpm_pkg::DIFF_W-1:0]  i_max_diff,
    output tpm_pkg::t_cmp_res           o_res
);

    logic [tpm_pkg::STAMP_W:0]   w_l_minus_c;
    logic [tpm_pkg::STAMP_W:0]   w_c_minus_l;
    logic [tpm_pkg::STAMP_W-1:0] w_abs;
    logic                        w_small;
    logic                        w_below_max;
    logic                        w_better;

    // absolute difference from both subtractions
    assign w_l_minus_c = {1'b0, i_lidar_stamp} - {1'b0, i_camera_stamp};
    assign w_c_minus_l = {1'b0, i_camera_stamp} - {1'b0, i_lidar_stamp};
    assign w_abs       = w_l_minus_c[tpm_pkg::STAMP_W] ? w_c_minus_l[tpm_pkg::STAMP_W-1:0]
                                                       : w_l_minus_c[tpm_pkg::STAMP_W-1:0];

    // threshold and best-so-far compares on the low bits
    assign w_small     = (w_abs[tpm_pkg::STAMP_W-1:tpm_pkg::DIFF_W] == '0);
    assign w_below_max = w_small && (w_abs[tpm_pkg::DIFF_W-1:0] < i_max_diff);
    assign w_better    = !i_found || (w_abs[tpm_pkg::DIFF_W-1:0] < i_best_diff);

    assign o_res.hit  = w_below_max && w_better;
    assign o_res.zero = (w_abs == '0);
    assign o_res.diff = w_abs[tpm_pkg::DIFF_W-1:0];

endmodule

// ----- rtl/core/timestamp_pair_matcher.sv -----
`timescale 1ns / 1ps

// Pairs lidar and camera frames by timestamp. A push beat (tuser lidar or camera)
// stores the stamp in that side's ring of DEPTH entries unless it repeats the
// previous stamp of that side. A search beat walks every pair, newest lidar first,
// through one shared subtract-and-compare unit fed by one camera read per cycle
// within a row; it ends early when a zero-difference match is taken and goes straight
// to the result when either side is empty. The result beat waits in an output register;
// s_axis_tready is low from the search beat until that register has been loaded.
// max_difference may be written at any time while the block is idle and never stalls.
module timestamp_pair_matcher #(
    parameter int unsigned DEPTH = tpm_pkg::DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [tpm_pkg::S_DATA_W-1:0] s_axis_tdata,  // stamp[31:0]
    input  logic [tpm_pkg::S_USER_W-1:0] s_axis_tuser,  // action[1:0]
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // camera_position[3:0], lidar_position[7:4], difference[27:8],
    // matched_lidar_stamp[59:28], zero fill[63:60]
    output logic [tpm_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic [tpm_pkg::M_USER_W-1:0] m_axis_tuser,  // found[0], already_fused[1]
    // max_difference write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tpm_pkg::DIFF_W-1:0]   i_cfg_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FW = $clog2(DEPTH + 1);

    // stamp stores
    logic [tpm_pkg::STAMP_W-1:0] lid_mem [DEPTH];
    logic [tpm_pkg::STAMP_W-1:0] cam_mem [DEPTH];

    tpm_pkg::t_state             r_state, n_state;
    logic [FW-1:0]               r_lfill, n_lfill, r_cfill, n_cfill;
    logic [PW-1:0]               r_lwr, n_lwr, r_cwr, n_cwr;
    logic [tpm_pkg::STAMP_W-1:0] r_lprev, n_lprev, r_cprev, n_cprev;
    logic                        r_lprev_v, n_lprev_v, r_cprev_v, n_cprev_v;
    logic [tpm_pkg::STAMP_W-1:0] r_fused, n_fused;
    logic                        r_fused_v, n_fused_v;
    logic [tpm_pkg::DIFF_W-1:0]  r_max, n_max;
    logic [PW-1:0]               r_lpos, n_lpos, r_cpos, n_cpos;
    logic                        r_found, n_found;
    logic [tpm_pkg::DIFF_W-1:0]  r_best_diff, n_best_diff;
    logic [PW-1:0]               r_best_l, n_best_l, r_best_c, n_best_c;
    logic [tpm_pkg::STAMP_W-1:0] r_best_stamp, n_best_stamp;
    logic                        r_m_valid, n_m_valid;
    logic [tpm_pkg::M_DATA_W-1:0] r_m_data, n_m_data;
    logic [tpm_pkg::M_USER_W-1:0] r_m_user, n_m_user;
    logic [tpm_pkg::STAMP_W-1:0] r_lid_rd, r_cam_rd;

    logic                        w_lid_we, w_cam_we;
    logic [PW-1:0]               w_lid_addr, w_cam_addr;
    logic                        w_in_beat;
    logic                        w_out_free;
    logic [FW-1:0]               w_lfill_m1, w_cfill_m1;
    logic [PW+3:0]               w_lpos_ext, w_cpos_ext;
    logic                        w_dup;
    tpm_pkg::t_cmp_res           w_cmp;

    // physical slot of a window position, position 0 being the oldest held
    function automatic logic [PW-1:0] f_phys(
        input logic [FW-1:0] fill,
        input logic [PW-1:0] wr,
        input logic [PW-1:0] pos
    );
        logic [PW:0] base;
        logic [PW:0] sum;
        base = (fill == FW'(DEPTH)) ? {1'b0, wr} : '0;
        sum  = base + {1'b0, pos};
        if (sum >= (PW + 1)'(DEPTH)) begin
            sum = sum - (PW + 1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    // ring pointer advance
    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] wr);
        logic [PW-1:0] nxt;
        nxt = (wr == PW'(DEPTH - 1)) ? '0 : wr + PW'(1);
        return nxt;
    endfunction

    assign s_axis_tready = (r_state == tpm_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_lfill_m1 = r_lfill - FW'(1);
    assign w_cfill_m1 = r_cfill - FW'(1);

    // positions reported in their low four bits
    assign w_lpos_ext = {4'b0, r_best_l};
    assign w_cpos_ext = {4'b0, r_best_c};

    // read addresses: lidar row fixed per row, camera walks down one per cycle
    assign w_lid_addr = f_phys(r_lfill, r_lwr, (r_state == tpm_pkg::ST_LROW) ? r_lpos : r_lpos);
    assign w_cam_addr = f_phys(r_cfill, r_cwr,
                               (r_state == tpm_pkg::ST_SCAN) ? r_cpos - PW'(1) : r_cpos);

    // shared compare unit
    tpm_pair_unit u_pair (
        .i_lidar_stamp  (r_lid_rd),
        .i_camera_stamp (r_cam_rd),
        .i_found        (r_found),
        .i_best_diff    (r_best_diff),
        .i_max_diff     (r_max),
        .o_res          (w_cmp)
    );

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_lfill      = r_lfill;
        n_cfill      = r_cfill;
        n_lwr        = r_lwr;
        n_cwr        = r_cwr;
        n_lprev      = r_lprev;
        n_lprev_v    = r_lprev_v;
        n_cprev      = r_cprev;
        n_cprev_v    = r_cprev_v;
        n_fused      = r_fused;
        n_fused_v    = r_fused_v;
        n_max        = r_max;
        n_lpos       = r_lpos;
        n_cpos       = r_cpos;
        n_found      = r_found;
        n_best_diff  = r_best_diff;
        n_best_l     = r_best_l;
        n_best_c     = r_best_c;
        n_best_stamp = r_best_stamp;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_data     = r_m_data;
        n_m_user     = r_m_user;
        w_lid_we     = 1'b0;
        w_cam_we     = 1'b0;
        w_dup        = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_max = i_cfg_data;
        end

        unique case (r_state)
            tpm_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    unique case (s_axis_tuser)
                        tpm_pkg::ACT_LIDAR: begin
                            w_dup = r_lprev_v && (r_lprev == s_axis_tdata);
                            if (!w_dup) begin
                                w_lid_we  = 1'b1;
                                n_lwr     = f_next(r_lwr);
                                n_lprev   = s_axis_tdata;
                                n_lprev_v = 1'b1;
                                if (r_lfill != FW'(DEPTH)) begin
                                    n_lfill = r_lfill + FW'(1);
                                end
                            end
                        end
                        tpm_pkg::ACT_CAMERA: begin
                            w_dup = r_cprev_v && (r_cprev == s_axis_tdata);
                            if (!w_dup) begin
                                w_cam_we  = 1'b1;
                                n_cwr     = f_next(r_cwr);
                                n_cprev   = s_axis_tdata;
                                n_cprev_v = 1'b1;
                                if (r_cfill != FW'(DEPTH)) begin
                                    n_cfill = r_cfill + FW'(1);
                                end
                            end
                        end
                        tpm_pkg::ACT_SEARCH: begin
                            n_found      = 1'b0;
                            n_best_diff  = '0;
                            n_best_l     = '0;
                            n_best_c     = '0;
                            n_best_stamp = '0;
                            n_lpos       = w_lfill_m1[PW-1:0];
                            n_cpos       = w_cfill_m1[PW-1:0];
                            if (r_lfill == '0 || r_cfill == '0) begin
                                n_state = tpm_pkg::ST_RESULT;
                            end else begin
                                n_state = tpm_pkg::ST_LROW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tpm_pkg::ST_LROW: begin
                // lidar row and newest camera entry are being read
                n_state = tpm_pkg::ST_SCAN;
            end
            tpm_pkg::ST_SCAN: begin
                if (w_cmp.hit) begin
                    n_found      = 1'b1;
                    n_best_diff  = w_cmp.diff;
                    n_best_l     = r_lpos;
                    n_best_c     = r_cpos;
                    n_best_stamp = r_lid_rd;
                end
                priority if (w_cmp.hit && w_cmp.zero) begin
                    n_state = tpm_pkg::ST_RESULT;
                end else if (r_cpos == '0) begin
                    if (r_lpos == '0) begin
                        n_state = tpm_pkg::ST_RESULT;
                    end else begin
                        n_lpos  = r_lpos - PW'(1);
                        n_cpos  = w_cfill_m1[PW-1:0];
                        n_state = tpm_pkg::ST_LROW;
                    end
                end else begin
                    n_cpos = r_cpos - PW'(1);
                end
            end
            tpm_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = tpm_pkg::ST_IDLE;
                    if (r_found) begin
                        n_m_data = {{tpm_pkg::M_PAD_W{1'b0}}, r_best_stamp, r_best_diff,
                                    w_lpos_ext[3:0], w_cpos_ext[3:0]};
                        if (r_fused_v && (r_fused == r_best_stamp)) begin
                            n_m_user = 2'b11;
                        end else begin
                            n_m_user  = 2'b01;
                            n_fused   = r_best_stamp;
                            n_fused_v = 1'b1;
                        end
                    end else begin
                        n_m_data = '0;
                        n_m_user = '0;
                    end
                end
            end
            default: begin
                n_state = tpm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpm_pkg::ST_IDLE;
            r_lfill   <= '0;
            r_cfill   <= '0;
            r_lwr     <= '0;
            r_cwr     <= '0;
            r_lprev_v <= 1'b0;
            r_cprev_v <= 1'b0;
            r_fused_v <= 1'b0;
            r_lprev   <= '0;
            r_cprev   <= '0;
            r_fused   <= '0;
            r_max     <= tpm_pkg::MAX_DIFF_RESET;
            r_m_valid <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lfill   <= n_lfill;
            r_cfill   <= n_cfill;
            r_lwr     <= n_lwr;
            r_cwr     <= n_cwr;
            r_lprev_v <= n_lprev_v;
            r_cprev_v <= n_cprev_v;
            r_fused_v <= n_fused_v;
            r_lprev   <= n_lprev;
            r_cprev   <= n_cprev;
            r_fused   <= n_fused;
            r_max     <= n_max;
            r_m_valid <= n_m_valid;
            r_found   <= n_found;
        end
    end

    // search and result payload
    always_ff @(posedge i_clk) begin
        r_lpos       <= n_lpos;
        r_cpos       <= n_cpos;
        r_best_diff  <= n_best_diff;
        r_best_l     <= n_best_l;
        r_best_c     <= n_best_c;
        r_best_stamp <= n_best_stamp;
        r_m_data     <= n_m_data;
        r_m_user     <= n_m_user;
    end

    // lidar store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_lid_we) begin
            lid_mem[r_lwr] <= s_axis_tdata;
        end
        r_lid_rd <= lid_mem[w_lid_addr];
    end

    // camera store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_cam_we) begin
            cam_mem[r_cwr] <= s_axis_tdata;
        end
        r_cam_rd <= cam_mem[w_cam_addr];
    end

endmodule

// ----- rtl/core/tpm_checker.sv -----
`timescale 1ns / 1ps

module tpm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [tpm_pkg::S_USER_W-1:0] s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [tpm_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic [tpm_pkg::M_USER_W-1:0] m_axis_tuser
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a search beat leaves the input not ready once it is taken
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == tpm_pkg::ACT_SEARCH) |=>
            !s_axis_tready)
        else $error("input ready right after a search beat");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("miss with nonzero fields");

    // the fill bits above the packed fields stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[tpm_pkg::M_DATA_W-1:tpm_pkg::M_DATA_W-4] == 4'b0))
        else $error("result fill bits set");

endmodule

bind timestamp_pair_matcher tpm_checker u_tpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
